### hw/rtl/cct_pkg.sv
// Shared types, constants and helpers of the conditional count table.
// No dependencies; imported by cct_div and conditional_count_table.

package cct_pkg;

  localparam int MAX_PARENTS    = 3;
  localparam int MAX_CATEGORIES = 8;
  localparam int TABLE_DEPTH    = 4096;
  localparam int COUNT_WIDTH    = 16;
  localparam int TOTAL_DEPTH    = TABLE_DEPTH / MAX_CATEGORIES;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int CFG_W          = $clog2(TOTAL_DEPTH);
  localparam int CAT_W          = 4;
  localparam int RES_W          = 16;
  localparam int PROB_W         = 16;
  localparam int REG_IDX_W      = 3;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NUM_PARENTS = 3'd0,
    REG_CHILD_CATS  = 3'd1,
    REG_PAR_A_CATS  = 3'd2,
    REG_PAR_B_CATS  = 3'd3,
    REG_PAR_C_CATS  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [CAT_W-1:0] parent_a_value;
    logic [CAT_W-1:0] parent_b_value;
    logic [CAT_W-1:0] parent_c_value;
    logic [CAT_W-1:0] child_value;
  } cct_in_t;

  typedef struct packed {
    logic [RES_W-1:0]  entry_count;
    logic [RES_W-1:0]  config_total;
    logic [PROB_W-1:0] probability;
    logic              error;
  } cct_out_t;

  function automatic logic [CAT_W-1:0] eff_cats(logic [CAT_W-1:0] r);
    logic [CAT_W-1:0] res;
    res = r;
    if (r == '0) res = CAT_W'(1);
    else if (r > CAT_W'(MAX_CATEGORIES)) res = CAT_W'(MAX_CATEGORIES);
    return res;
  endfunction

  function automatic logic in_range(logic [CAT_W-1:0] v, logic [CAT_W-1:0] cats);
    return (v != '0) && (v <= cats);
  endfunction

endpackage

### hw/rtl/cct_div.sv
// Radix-2 restoring divider that yields the Q0.16 fraction count/total.
// Depends on cct_pkg; instantiated by conditional_count_table.

module cct_div import cct_pkg::*; #(
  parameter int CountWidth = COUNT_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [CountWidth-1:0] dividend_i,
  input  logic [CountWidth-1:0] divisor_i,
  output logic                  done_o,
  output logic [PROB_W-1:0]     quot_o
);

  localparam int StepW = $clog2(PROB_W + 1);

  logic [CountWidth:0]   rem_q, rem_d, rem_sh;
  logic [CountWidth-1:0] div_q;
  logic [PROB_W-1:0]     quo_q, quo_d;
  logic [StepW-1:0]      step_q, step_d;
  logic                  run_q, run_d, done_q, done_d;
  logic                  fits;

  assign rem_sh = {rem_q[CountWidth-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, dividend_i};
      quo_d  = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = fits ? rem_sh - {1'b0, div_q} : rem_sh;
      quo_d  = {quo_q[PROB_W-2:0], fits};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(PROB_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) div_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q) && !run_q)
    else $error("divider finished without running");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> step_q < StepW'(PROB_W))
    else $error("divider step count overran");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !start_i && (rem_q < {1'b0, div_q}) |=> rem_q < {1'b0, div_q})
    else $error("divider remainder overflowed");

endmodule

### hw/rtl/conditional_count_table.sv
// Top level of the conditional count table: config registers, sequencer, stores.
// Depends on cct_pkg and cct_div.
//
//   channel   ports                                    transaction when
//   command   start, busy, cmd_i                       start && !busy
//   result    done_o, result_o                         done_o (one cycle)
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,   cfg_valid_i && cfg_ready_o
//             cfg_data_i
//
// Add and query pass through S_INDEX, S_READ, S_UPDATE and S_DIV; the 16-step divider dominates.
// Clear and reset both sweep the count and total stores, one entry a cycle.
// Busy stays high through the reset sweep; a clear reports its result at its end.
// Errored and unused commands answer without the divider, from S_INDEX or S_IDLE. Results cannot be stalled.

module conditional_count_table import cct_pkg::*; #(
  parameter int CountWidth = COUNT_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cct_in_t              cmd_i,
  output logic                 done_o,
  output cct_out_t             result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CAT_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INDEX, S_READ, S_UPDATE, S_DIV
  } state_e;

  localparam int CfgPW = CFG_W + CAT_W;
  localparam int IdxPW = IDX_W + CAT_W;

  state_e                state_q;
  cct_in_t               item_q;
  cct_out_t              res_q;
  logic                  done_q, pend_q, err_q;
  logic [1:0]            step_q;
  logic [IDX_W-1:0]      clr_q, idx_q;
  logic [CFG_W-1:0]      cfg_q;
  logic [CountWidth-1:0] cnt_q, tot_q;

  logic [1:0]            num_par_q, np;
  logic [CAT_W-1:0]      child_cat_q, par_a_cat_q, par_b_cat_q, par_c_cat_q;

  logic [CountWidth-1:0] count_mem [TABLE_DEPTH];
  logic [CountWidth-1:0] total_mem [TOTAL_DEPTH];
  logic [CountWidth-1:0] cnt_rd_q, tot_rd_q, cnt_new, tot_new;
  logic                  mem_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [CFG_W-1:0]      tot_waddr;
  logic [CountWidth-1:0] cnt_wdata, tot_wdata;

  logic [CAT_W-1:0]      cc, pc, pv;
  logic                  par_step, par_ok, child_ok, is_add;
  logic [CfgPW-1:0]      cfg_prod;
  logic [IdxPW-1:0]      idx_prod;
  logic                  div_done;
  logic [PROB_W-1:0]     div_quot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_par_q   <= '0;
      child_cat_q <= CAT_W'(2);
      par_a_cat_q <= CAT_W'(2);
      par_b_cat_q <= CAT_W'(2);
      par_c_cat_q <= CAT_W'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_NUM_PARENTS: num_par_q   <= cfg_data_i[1:0];
        REG_CHILD_CATS:  child_cat_q <= cfg_data_i;
        REG_PAR_A_CATS:  par_a_cat_q <= cfg_data_i;
        REG_PAR_B_CATS:  par_b_cat_q <= cfg_data_i;
        REG_PAR_C_CATS:  par_c_cat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign np = (num_par_q > 2'(MAX_PARENTS)) ? 2'(MAX_PARENTS) : num_par_q;
  assign cc = eff_cats(child_cat_q);

  always_comb begin
    case (step_q)
      2'd0:    begin pc = eff_cats(par_a_cat_q); pv = item_q.parent_a_value; end
      2'd1:    begin pc = eff_cats(par_b_cat_q); pv = item_q.parent_b_value; end
      default: begin pc = eff_cats(par_c_cat_q); pv = item_q.parent_c_value; end
    endcase
  end

  assign par_step = step_q < np;
  assign par_ok   = in_range(pv, pc);
  assign child_ok = in_range(item_q.child_value, cc);
  assign cfg_prod = CfgPW'(cfg_q) * CfgPW'(pc) + CfgPW'(pv - CAT_W'(1));
  assign idx_prod = IdxPW'(cfg_q) * IdxPW'(cc) + IdxPW'(item_q.child_value - CAT_W'(1));

  assign is_add  = item_q.command == CMD_ADD;
  assign cnt_new = (is_add && cnt_rd_q != '1) ? cnt_rd_q + CountWidth'(1) : cnt_rd_q;
  assign tot_new = (is_add && tot_rd_q != '1) ? tot_rd_q + CountWidth'(1) : tot_rd_q;

  always_comb begin
    mem_we    = 1'b0;
    cnt_waddr = idx_q;
    tot_waddr = cfg_q;
    cnt_wdata = cnt_new;
    tot_wdata = tot_new;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      cnt_waddr = clr_q;
      tot_waddr = clr_q[CFG_W-1:0];
      cnt_wdata = '0;
      tot_wdata = '0;
    end else if (state_q == S_UPDATE && is_add) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) count_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= count_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) total_mem[tot_waddr] <= tot_wdata;
    tot_rd_q <= total_mem[cfg_q];
  end

  cct_div #(.CountWidth(CountWidth)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (state_q == S_UPDATE),
    .dividend_i (cnt_new),
    .divisor_i  (tot_new),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      err_q   <= 1'b0;
      step_q  <= '0;
      res_q   <= '0;
      item_q  <= '0;
      cfg_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      tot_q   <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
            done_q  <= pend_q;
            pend_q  <= 1'b0;
            res_q   <= '0;
          end else begin
            done_q  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            item_q <= cmd_i;
            step_q <= '0;
            cfg_q  <= '0;
            err_q  <= 1'b0;
            case (cmd_i.command) inside
              CMD_CLEAR: begin
                state_q <= S_CLEAR;
                clr_q   <= '0;
                pend_q  <= 1'b1;
                done_q  <= 1'b0;
              end
              CMD_ADD, CMD_QUERY: begin
                state_q <= S_INDEX;
                done_q  <= 1'b0;
              end
              default: begin
                done_q <= 1'b1;
                res_q  <= '0;
              end
            endcase
          end else begin
            done_q <= 1'b0;
          end
        end
        S_INDEX: begin
          step_q <= step_q + 2'd1;
          if (par_step) begin
            done_q <= 1'b0;
            if (!par_ok) err_q <= 1'b1;
            else cfg_q <= cfg_prod[CFG_W-1:0];
          end else if (err_q || !child_ok) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            res_q   <= '{entry_count: '0, config_total: '0, probability: '0, error: 1'b1};
          end else begin
            done_q  <= 1'b0;
            idx_q   <= idx_prod[IDX_W-1:0];
            state_q <= S_READ;
          end
        end
        S_READ: begin
          done_q  <= 1'b0;
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          done_q  <= 1'b0;
          cnt_q   <= cnt_new;
          tot_q   <= tot_new;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q                <= S_IDLE;
            done_q                 <= 1'b1;
            res_q.entry_count      <= RES_W'(cnt_q);
            res_q.config_total     <= RES_W'(tot_q);
            res_q.error            <= 1'b0;
            if (tot_q == '0) res_q.probability <= '0;
            else if (cnt_q >= tot_q) res_q.probability <= '1;
            else res_q.probability <= div_quot;
          end else begin
            done_q <= 1'b0;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = state_q != S_IDLE;
  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result reported while a transaction is still in work");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.error |->
      result_o.entry_count == '0 && result_o.config_total == '0 &&
      result_o.probability == '0)
    else $error("errored transaction carries nonzero fields");

  a_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.config_total == '0 |-> result_o.probability == '0)
    else $error("probability nonzero with zero total");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

endmodule
